>>> hw/rtl/positional_array_insert_delete_top_macros.svh
// Assertion macros shared by the checker of the positional list store.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while rst_n is low.
`define PAI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and silenced while rst_n is low.
`define PAI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pai_pkg.sv
// Shared constants, codes and control types of the positional list store.
package pai_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 8;
  localparam int OP_W      = 2;
  localparam int STS_W     = 2;
  localparam int SLOT_W    = 7;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [STS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // perform the accepted item's op
    logic dump_step;  // emit one dump beat and rotate the list
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_go;    // the presented item is a dump of a non-empty list
    logic dump_last;  // the current dump beat is the final one
  } sts_t;

endpackage

>>> hw/rtl/pai_ctrl.sv
// Controller state machine of the positional list store.
module pai_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output pai_pkg::cmd_t  cmd,
  input  pai_pkg::sts_t  sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic can_load;

  // The output register may take a new beat when empty or being drained.
  assign can_load      = !out_valid_r || !out_stall;
  assign in_stall      = !((state_r == S_IDLE) && can_load);
  assign cmd.exec      = in_valid && !in_stall;
  assign cmd.dump_step = (state_r == S_DUMP) && can_load;
  assign out_valid     = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec && sts.dump_go) state_nxt = S_DUMP;
      end
      S_DUMP: begin
        if (cmd.dump_step && sts.dump_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (can_load) begin
      out_valid_nxt = (cmd.exec && !sts.dump_go) || cmd.dump_step;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/pai_dpath.sv
// Datapath of the positional list store: entry registers, count and output register.
module pai_dpath #(
  parameter int DEPTH = pai_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pai_pkg::cmd_t                     cmd,
  output pai_pkg::sts_t                     sts,
  input  logic [pai_pkg::OP_W-1:0]          in_op,
  input  logic [pai_pkg::POS_W-1:0]         in_position,
  input  logic signed [pai_pkg::DATA_W-1:0] in_value,
  output logic [pai_pkg::STS_W-1:0]         out_status,
  output logic signed [pai_pkg::DATA_W-1:0] out_element,
  output logic [pai_pkg::SLOT_W-1:0]        out_slot,
  output logic                              out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = pai_pkg::POS_W + 1;

  logic [pai_pkg::DATA_W-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;

  logic [CMP_W-1:0]           pos_ext, cnt_ext;
  logic                       cnt_zero, ins_ok, del_ok, last_beat;
  logic [pai_pkg::STS_W-1:0]  op_status;

  logic [pai_pkg::STS_W-1:0]  out_status_r;
  logic [pai_pkg::DATA_W-1:0] out_element_r;
  logic [pai_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_last_r;

  assign pos_ext  = {1'b0, in_position};
  assign cnt_ext  = CMP_W'(count_r);
  assign cnt_zero = (count_r == '0);

  assign ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                  && (count_r != CNT_W'(DEPTH));
  assign del_ok = !cnt_zero && (pos_ext != '0) && (pos_ext <= cnt_ext);

  assign last_beat = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  assign sts.dump_go   = (in_op == pai_pkg::OP_DUMP) && !cnt_zero;
  assign sts.dump_last = last_beat;

  // Status and new count of a single-result op.
  always_comb begin
    op_status = pai_pkg::ST_OK;
    count_nxt = count_r;
    case (in_op)
      pai_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      pai_pkg::OP_INSERT: begin
        if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
          op_status = pai_pkg::ST_BADPOS;
        end else if (count_r == CNT_W'(DEPTH)) begin
          op_status = pai_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      pai_pkg::OP_DELETE: begin
        if (cnt_zero) begin
          op_status = pai_pkg::ST_EMPTY;
        end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
          op_status = pai_pkg::ST_BADPOS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      pai_pkg::OP_DUMP: begin
        if (cnt_zero) op_status = pai_pkg::ST_EMPTY;
      end
      default: op_status = pai_pkg::ST_OK;
    endcase
  end

  // Each entry reads only its own neighbors and the head of the list. A dump
  // rotates the occupied part of the list by one per beat, so after count
  // beats the list is back in its original order.
  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    localparam logic [CMP_W-1:0] GI = CMP_W'(g);
    logic [pai_pkg::DATA_W-1:0] prev_w, next_w, ent_nxt;

    if (g == 0) begin : g_first
      assign prev_w = entries_r[0];
    end else begin : g_mid_lo
      assign prev_w = entries_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = entries_r[g];
    end else begin : g_mid_hi
      assign next_w = entries_r[g+1];
    end

    always_comb begin
      ent_nxt = entries_r[g];
      if (cmd.exec && (in_op == pai_pkg::OP_INSERT) && ins_ok) begin
        if (GI == pos_ext - CMP_W'(1)) begin
          ent_nxt = in_value;
        end else if (GI >= pos_ext) begin
          ent_nxt = prev_w;
        end
      end else if (cmd.exec && (in_op == pai_pkg::OP_DELETE) && del_ok) begin
        if (GI >= pos_ext - CMP_W'(1)) ent_nxt = next_w;
      end else if (cmd.dump_step) begin
        if (GI + CMP_W'(1) == cnt_ext) begin
          ent_nxt = entries_r[0];
        end else if (GI + CMP_W'(1) < cnt_ext) begin
          ent_nxt = next_w;
        end
      end
    end

    always_ff @(posedge clk) begin
      entries_r[g] <= ent_nxt;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.exec) begin
      idx_nxt = '0;
    end else if (cmd.dump_step) begin
      idx_nxt = last_beat ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.exec) count_r <= count_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !sts.dump_go) begin
      out_status_r  <= op_status;
      out_element_r <= '0;
      out_slot_r    <= pai_pkg::SLOT_W'(count_nxt);
      out_last_r    <= 1'b1;
    end else if (cmd.dump_step) begin
      out_status_r  <= pai_pkg::ST_OK;
      out_element_r <= entries_r[0];
      out_slot_r    <= pai_pkg::SLOT_W'(idx_r) + pai_pkg::SLOT_W'(1);
      out_last_r    <= last_beat;
    end
  end

  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_slot    = out_slot_r;
  assign out_last    = out_last_r;

endmodule

>>> hw/rtl/positional_array_insert_delete_top.sv
// Top level of the positional list store: controller plus datapath.
//
// This block keeps an ordered list of up to DEPTH signed 32-bit values and
// answers one request per input beat: clear, insert at a 1-based position,
// delete at a 1-based position, or dump the whole list. Clear, insert and
// delete each produce exactly one result beat carrying a status and the new
// count in out_slot, and the block can take such a request every clock cycle
// as long as the result side keeps up, because the whole shift of the list
// is done in parallel inside a register array. A dump of a list holding n
// entries produces n result beats, one entry per beat with its position in
// out_slot and out_last set on the final one; the input is stalled during
// that time. The beats come from a single read-out point: every dump beat
// takes the head of the list and rotates the occupied entries by one,
// which leaves the list in its original order once the dump is done.
// A dump of an empty list gives one beat with status "list empty". Rejected
// requests (bad position, delete from an empty list, insert into a full
// list) give a status beat and leave the list untouched. Results pass
// through an output register, so a new request is taken in the same cycle
// that a waiting result is taken by the receiver. Entries beyond the count
// are never shown, and reset only clears the count and the control state.
module positional_array_insert_delete_top #(
  parameter int DEPTH = pai_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pai_pkg::OP_W-1:0]          in_op,
  input  logic [pai_pkg::POS_W-1:0]         in_position,
  input  logic signed [pai_pkg::DATA_W-1:0] in_value,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pai_pkg::STS_W-1:0]         out_status,
  output logic signed [pai_pkg::DATA_W-1:0] out_element,
  output logic [pai_pkg::SLOT_W-1:0]        out_slot,
  output logic                              out_last
);

  pai_pkg::cmd_t cmd;
  pai_pkg::sts_t sts;

  // The controller decides when a beat is accepted and when a dump beat is
  // emitted; it never sees payload.
  pai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the list, the count, the dump index and the output
  // register that carries each result beat.
  pai_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_op),
    .in_position (in_position),
    .in_value    (in_value),
    .out_status  (out_status),
    .out_element (out_element),
    .out_slot    (out_slot),
    .out_last    (out_last)
  );

endmodule

>>> hw/rtl/pai_checker.sv
// Port-level checker of the positional list store and its bind statement.
`include "positional_array_insert_delete_top_macros.svh"

module pai_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [pai_pkg::STS_W-1:0]         out_status,
  input logic signed [pai_pkg::DATA_W-1:0] out_element,
  input logic [pai_pkg::SLOT_W-1:0]        out_slot,
  input logic                              out_last
);

  // A stalled result beat stays put.
  `PAI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_element)
    && $stable(out_slot) && $stable(out_last), "stalled result beat changed")

  // Only dump entries are non-final, and they always report success.
  `PAI_ASSERT_NOW(a_mid_ok, out_valid && !out_last, out_status == pai_pkg::ST_OK,
    "non-final beat with bad status")

  // No request is taken while a dump still has beats to deliver.
  `PAI_ASSERT_NOW(a_dump_block, out_valid && !out_last, in_stall,
    "request accepted during a dump")

  // A non-final dump beat is always followed by another beat.
  `PAI_ASSERT_NEXT(a_dump_cont, out_valid && !out_last, out_valid,
    "dump ended without final beat")

  // A rejected request never carries an element value.
  `PAI_ASSERT_NOW(a_err_zero, out_valid && (out_status != pai_pkg::ST_OK),
    out_element == '0, "error beat with nonzero element")

endmodule

bind positional_array_insert_delete_top pai_checker u_pai_checker (.*);

>>> tb/pai_list_checker.sv
// Checker for the positional list store: keeps a shadow list and compares result beats.
`timescale 1ns / 100ps

module pai_list_checker #(
  parameter int DEPTH = pai_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [pai_pkg::OP_W-1:0]          in_op,
  input  logic [pai_pkg::POS_W-1:0]         in_position,
  input  logic signed [pai_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [pai_pkg::STS_W-1:0]         out_status,
  input  logic signed [pai_pkg::DATA_W-1:0] out_element,
  input  logic [pai_pkg::SLOT_W-1:0]        out_slot,
  input  logic                              out_last,
  output int                                mismatches,
  output int                                pending,
  output int                                list_fill,
  output int                                requests_seen,
  output int                                beats_seen
);

  typedef struct packed {
    logic [pai_pkg::STS_W-1:0]         status;
    logic signed [pai_pkg::DATA_W-1:0] element;
    logic [pai_pkg::SLOT_W-1:0]        slot;
    logic                              last;
  } result_beat_t;

  logic signed [pai_pkg::DATA_W-1:0] shadow_list [DEPTH];
  result_beat_t                      expected_beats [$];

  task automatic push_beat(input logic [pai_pkg::STS_W-1:0] status,
                           input logic signed [pai_pkg::DATA_W-1:0] element,
                           input int slot, input logic last);
    result_beat_t beat;
    beat.status  = status;
    beat.element = element;
    beat.slot    = slot[pai_pkg::SLOT_W-1:0];
    beat.last    = last;
    expected_beats.push_back(beat);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] result mismatch: %s", $time, what);
    end
  endtask

  // Applies one accepted request to the shadow list and queues its result beats.
  task automatic apply_request(input logic [pai_pkg::OP_W-1:0] op,
                               input logic [pai_pkg::POS_W-1:0] position,
                               input logic signed [pai_pkg::DATA_W-1:0] value);
    int pos;
    pos = int'(position);
    requests_seen++;
    case (op)
      pai_pkg::OP_CLEAR: begin
        list_fill = 0;
        push_beat(pai_pkg::ST_OK, '0, 0, 1'b1);
      end
      pai_pkg::OP_INSERT: begin
        // The position is checked before fullness.
        if (pos < 1 || pos > list_fill + 1) begin
          push_beat(pai_pkg::ST_BADPOS, '0, list_fill, 1'b1);
        end else if (list_fill >= DEPTH) begin
          push_beat(pai_pkg::ST_FULL, '0, list_fill, 1'b1);
        end else begin
          for (int i = list_fill; i >= pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos-1] = value;
          list_fill++;
          push_beat(pai_pkg::ST_OK, '0, list_fill, 1'b1);
        end
      end
      pai_pkg::OP_DELETE: begin
        // Emptiness is checked before the position.
        if (list_fill == 0) begin
          push_beat(pai_pkg::ST_EMPTY, '0, list_fill, 1'b1);
        end else if (pos < 1 || pos > list_fill) begin
          push_beat(pai_pkg::ST_BADPOS, '0, list_fill, 1'b1);
        end else begin
          for (int i = pos - 1; i + 1 < list_fill; i++) shadow_list[i] = shadow_list[i+1];
          list_fill--;
          push_beat(pai_pkg::ST_OK, '0, list_fill, 1'b1);
        end
      end
      pai_pkg::OP_DUMP: begin
        if (list_fill == 0) begin
          push_beat(pai_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < list_fill; i++) begin
            push_beat(pai_pkg::ST_OK, shadow_list[i], i + 1, (i + 1 == list_fill));
          end
        end
      end
      default: begin
        note_mismatch("request taken with an unknown op");
      end
    endcase
  endtask

  task automatic check_beat();
    result_beat_t want;
    beats_seen++;
    if (expected_beats.size() == 0) begin
      note_mismatch($sformatf("unexpected beat status=%0d element=%0d slot=%0d last=%0d",
                              out_status, out_element, out_slot, out_last));
    end else begin
      want = expected_beats.pop_front();
      if (out_status !== want.status)
        note_mismatch($sformatf("status expected %0d got %0d", want.status, out_status));
      if (out_element !== want.element)
        note_mismatch($sformatf("element expected %0d got %0d",
                                $signed(want.element), out_element));
      if (out_slot !== want.slot)
        note_mismatch($sformatf("slot expected %0d got %0d", want.slot, out_slot));
      if (out_last !== want.last)
        note_mismatch($sformatf("last expected %0d got %0d", want.last, out_last));
    end
  endtask

  // A result beat can never belong to a request taken at the same edge, so the
  // comparison goes first.
  always @(posedge clk) begin
    if (!rst_n) begin
      list_fill = 0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) apply_request(in_op, in_position, in_value);
    end
    pending = expected_beats.size();
  end

endmodule

>>> tb/tb_positional_array_insert_delete_top.sv
// Testbench top for the positional list store: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_positional_array_insert_delete_top;

  // Length of the long result hold-off, in clock cycles.
  localparam int HOLD_CYCLES   = 120;
  // Cycles to watch for stray beats once nothing is expected any more.
  localparam int SETTLE_CYCLES = 20;
  // Random requests per stall phase.
  localparam int PHASE_ITEMS   = 103;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [pai_pkg::OP_W-1:0]          in_op;
  logic [pai_pkg::POS_W-1:0]         in_position;
  logic signed [pai_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_stall;
  logic [pai_pkg::STS_W-1:0]         out_status;
  logic signed [pai_pkg::DATA_W-1:0] out_element;
  logic [pai_pkg::SLOT_W-1:0]        out_slot;
  logic                              out_last;

  // Idle rates in percent for the request side and the result side.
  int   in_idle_pct;
  int   out_idle_pct;
  // Bumped by the stimulus to make the result side hold off for a long stretch.
  int   hold_requests;
  // Hold-offs the result side has carried out so far.
  int   holds_served;

  int mismatches;
  int pending;
  int list_fill;
  int requests_seen;
  int beats_seen;

  positional_array_insert_delete_top #(
    .DEPTH(pai_pkg::DEPTH_DEF)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_position(in_position),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_element(out_element),
    .out_slot   (out_slot),
    .out_last   (out_last)
  );

  pai_list_checker #(
    .DEPTH(pai_pkg::DEPTH_DEF)
  ) u_list_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_position  (in_position),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_element  (out_element),
    .out_slot     (out_slot),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .pending      (pending),
    .list_fill    (list_fill),
    .requests_seen(requests_seen),
    .beats_seen   (beats_seen)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Safety net: a hung handshake must not keep the run alive forever. This is
  // far beyond the slowest correct run, even with every dump at full depth.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side. Each falling edge it decides whether to stall the next beat.
  // When the stimulus asks for a hold-off, stall is kept high for a fixed
  // number of cycles counted here, so the block backs up and stalls its input.
  initial begin
    out_stall    = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall = ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // Presents one request beat, starting at a falling edge. A random number of
  // idle cycles may come first. Returns at the rising edge that accepts it,
  // leaving valid high so that the next request can follow back to back.
  task automatic present_request(input logic [pai_pkg::OP_W-1:0] op,
                                 input logic [pai_pkg::POS_W-1:0] pos,
                                 input logic signed [pai_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_position = pos;
    in_value    = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer_request(input logic [pai_pkg::OP_W-1:0] op,
                               input logic [pai_pkg::POS_W-1:0] pos,
                               input logic signed [pai_pkg::DATA_W-1:0] value);
    @(negedge clk);
    present_request(op, pos, value);
  endtask

  // Picks a request from the current list fill, read at the falling edge after
  // the previous beat was taken. Inserts outweigh deletes, so the list keeps
  // climbing to full and the full case comes up often; an occasional clear
  // brings it back down. Most positions are legal for the op, the rest sit
  // just outside the legal range or anywhere in the 8-bit field.
  task automatic random_request();
    logic [pai_pkg::OP_W-1:0]          op;
    logic [pai_pkg::POS_W-1:0]         pos;
    logic signed [pai_pkg::DATA_W-1:0] value;
    int                                roll;
    int                                limit;
    @(negedge clk);
    roll = $urandom_range(99);
    if (roll < 3)       op = pai_pkg::OP_CLEAR;
    else if (roll < 15) op = pai_pkg::OP_DUMP;
    else if (roll < 63) op = pai_pkg::OP_INSERT;
    else                op = pai_pkg::OP_DELETE;
    limit = (op == pai_pkg::OP_INSERT) ? list_fill + 1 : list_fill;
    roll  = $urandom_range(99);
    if (roll < 80 && limit > 0) pos = pai_pkg::POS_W'($urandom_range(limit, 1));
    else if (roll < 87)         pos = '0;
    else if (roll < 94)         pos = pai_pkg::POS_W'(limit + 1);
    else                        pos = pai_pkg::POS_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 8)       value = 32'sh7FFF_FFFF;
    else if (roll < 16) value = 32'sh8000_0000;
    else if (roll < 22) value = '0;
    else if (roll < 26) value = -32'sd1;
    else                value = $urandom;
    present_request(op, pos, value);
  endtask

  // Drops valid and waits until every expected result beat has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = pai_pkg::OP_CLEAR;
    in_position   = '0;
    in_value      = '0;
    hold_requests = 0;
    // The first stretch runs with a mostly busy sender and a stall-heavy receiver.
    in_idle_pct   = 10;
    out_idle_pct  = 56;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Everything on an empty list is rejected first: dump and
    // delete report an empty list, and delete checks emptiness before the
    // position. Inserts then build a short list at the front, the end and the
    // middle with the extreme values.
    offer_request(pai_pkg::OP_DUMP,   8'd0,   32'sd0);
    offer_request(pai_pkg::OP_DELETE, 8'd1,   32'sd0);
    offer_request(pai_pkg::OP_DELETE, 8'd0,   32'sd0);
    offer_request(pai_pkg::OP_INSERT, 8'd0,   32'sd7);
    offer_request(pai_pkg::OP_INSERT, 8'd2,   32'sd7);
    offer_request(pai_pkg::OP_INSERT, 8'd1,   32'sh7FFF_FFFF);
    offer_request(pai_pkg::OP_INSERT, 8'd1,   32'sh8000_0000);
    offer_request(pai_pkg::OP_INSERT, 8'd3,   32'sd0);
    offer_request(pai_pkg::OP_INSERT, 8'd2,   -32'sd1);
    // Position and value are ignored by a dump.
    offer_request(pai_pkg::OP_DUMP,   8'd255, 32'sh5A5A_5A5A);
    // Bad positions on a list of four: zero, just past the end, far past it.
    offer_request(pai_pkg::OP_DELETE, 8'd0,   32'sd0);
    offer_request(pai_pkg::OP_DELETE, 8'd5,   32'sd0);
    offer_request(pai_pkg::OP_INSERT, 8'd255, 32'sd9);
    offer_request(pai_pkg::OP_DELETE, 8'd255, 32'sd0);
    // Delete from the middle, the end and the front.
    offer_request(pai_pkg::OP_DELETE, 8'd2,   32'sd0);
    offer_request(pai_pkg::OP_DELETE, 8'd3,   32'sd0);
    offer_request(pai_pkg::OP_DELETE, 8'd1,   32'sd0);
    offer_request(pai_pkg::OP_DUMP,   8'd0,   32'sd0);
    offer_request(pai_pkg::OP_CLEAR,  8'hFF,  -32'sd1);
    offer_request(pai_pkg::OP_DUMP,   8'd0,   32'sd0);
    offer_request(pai_pkg::OP_INSERT, 8'd1,   32'sh1234_5678);
    offer_request(pai_pkg::OP_CLEAR,  8'd0,   32'sd0);
    drain_results();

    // Pressure: the result side holds off for a long stretch while the list is
    // filled to the brim, so the output register backs up and the input stalls.
    // At full depth an insert at the next position reports a full list, and one
    // past that still reports a bad position because the position is checked
    // first. A dump of the full list then gives its longest burst of beats.
    hold_requests++;
    for (int k = 0; k < pai_pkg::DEPTH_DEF; k++) begin
      offer_request(pai_pkg::OP_INSERT, pai_pkg::POS_W'($urandom_range(k + 1, 1)),
                    $urandom);
    end
    offer_request(pai_pkg::OP_INSERT, pai_pkg::POS_W'(pai_pkg::DEPTH_DEF + 1), $urandom);
    offer_request(pai_pkg::OP_INSERT, pai_pkg::POS_W'(pai_pkg::DEPTH_DEF + 2), $urandom);
    offer_request(pai_pkg::OP_DUMP, pai_pkg::POS_W'($urandom_range(255)), $urandom);
    // The sender now pauses until every expected beat has been seen.
    drain_results();

    // Random part in three stall phases: sender-light and receiver-heavy, the
    // other way round, and finally with no idling on either side.
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 56 : 0;
      out_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 10 : 0;
      repeat (PHASE_ITEMS) random_request();
    end

    // Wind down: wait for the last beats, then watch a little longer for any
    // stray beat the block might still produce.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d result beats, including full-list and",
             requests_seen, beats_seen);
    $display("empty-list cases, a long result hold-off and three stall mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> positional_array_insert_delete_top.f
+incdir+hw/rtl
hw/rtl/pai_pkg.sv
hw/rtl/pai_ctrl.sv
hw/rtl/pai_dpath.sv
hw/rtl/positional_array_insert_delete_top.sv
hw/rtl/pai_checker.sv
tb/pai_list_checker.sv
tb/tb_positional_array_insert_delete_top.sv
